// File: design/rbse_pkg.sv
package rbse_pkg;

	// Fixed-point format and field widths.
	localparam int FRAC_BITS = 24;
	localparam int COORD_W   = 48;
	localparam int WEIGHT_W  = 32;
	localparam int KNOT_W    = 32;
	localparam int PARAM_W   = FRAC_BITS + 1;
	localparam int CFG_W     = FRAC_BITS + 1;
	localparam int ORDER_W   = 2;
	localparam int ACT_W     = 2;
	localparam int SLOT_W    = 3;
	localparam int CIDX_W    = 2;

	// Intermediates saturate to plus or minus two to the sixtieth.
	localparam int SAT_EXP = 60;
	localparam int VAL_W   = SAT_EXP + 2;
	localparam int DIFF_W  = VAL_W + 1;
	localparam int SUM_W   = DIFF_W + 1;
	localparam int MAG_W   = VAL_W;

	// Number of control points and knots.
	localparam int NUM_PTS   = 4;
	localparam int NUM_KNOTS = 6;
	localparam int NUM_COMP  = 4;

	typedef logic signed [COORD_W-1:0] coord_t;
	typedef logic signed [KNOT_W-1:0]  knot_t;
	typedef logic signed [VAL_W-1:0]   val_t;
	typedef logic signed [DIFF_W-1:0]  dv_t;
	typedef logic        [MAG_W-1:0]   mag_t;
	typedef val_t [NUM_COMP-1:0]       row_t;

	localparam mag_t SAT_MAG = mag_t'(1) << SAT_EXP;
	localparam logic signed [SUM_W-1:0] SUM_SAT = SUM_W'(1) << SAT_EXP;
	localparam val_t ONE_VAL = val_t'(1) << FRAC_BITS;
	localparam logic [PARAM_W-1:0] PARAM_ONE = PARAM_W'(1) << FRAC_BITS;
	localparam val_t OUT_HI = (val_t'(1) << (COORD_W - 1)) - val_t'(1);
	localparam val_t OUT_LO = -(val_t'(1) << (COORD_W - 1));

	// Actions of an input word.
	localparam logic [ACT_W-1:0] ACT_POINT = 2'd0;
	localparam logic [ACT_W-1:0] ACT_KNOT  = 2'd1;
	localparam logic [ACT_W-1:0] ACT_EVAL  = 2'd2;

	// Configuration register indexes.
	localparam logic [CIDX_W-1:0] REG_ORDER  = 2'd0;
	localparam logic [CIDX_W-1:0] REG_START  = 2'd1;
	localparam logic [CIDX_W-1:0] REG_END    = 2'd2;
	localparam logic [CIDX_W-1:0] REG_FLOOR  = 2'd3;

	typedef struct packed {
		logic [ORDER_W-1:0] seg_order;
		logic [CFG_W-1:0]   range_start;
		logic [CFG_W-1:0]   range_end;
		logic [CFG_W-1:0]   weight_floor;
	} cfg_t;

	typedef struct packed {
		logic [ACT_W-1:0]    kind;
		logic [SLOT_W-1:0]   slot;
		coord_t              coord_x;
		coord_t              coord_y;
		coord_t              coord_z;
		logic [WEIGHT_W-1:0] weight;
		knot_t               knot_value;
		logic [PARAM_W-1:0]  param_t;
	} cmd_t;

	typedef struct packed {
		logic valid;
		cmd_t cmd;
	} qhead_t;

	// Magnitude of a signed difference.
	function automatic mag_t mag_of(dv_t v);
		logic [DIFF_W-1:0] t;
		t = v[DIFF_W-1] ? DIFF_W'(-v) : DIFF_W'(v);
		return t[MAG_W-1:0];
	endfunction

	// Saturating sum of two intermediates.
	function automatic val_t sat_add(dv_t a, dv_t b);
		logic signed [SUM_W-1:0] s;
		s = SUM_W'(a) + SUM_W'(b);
		if (s > SUM_SAT) begin
			s = SUM_SAT;
		end else if (s < -SUM_SAT) begin
			s = -SUM_SAT;
		end
		return val_t'(s);
	endfunction

	// Clamp an intermediate to the output coordinate width.
	function automatic coord_t sat_out(val_t v);
		val_t t;
		t = v;
		if (t > OUT_HI) begin
			t = OUT_HI;
		end else if (t < OUT_LO) begin
			t = OUT_LO;
		end
		return t[COORD_W-1:0];
	endfunction

endpackage

// File: design/rbse_mul.sv
module rbse_mul import rbse_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic start,
	input  dv_t  op_a,
	input  dv_t  op_b,
	output logic done,
	output val_t prod
);

	localparam int HALF_W = 32;
	localparam int PP_W   = 2 * HALF_W;
	localparam int PROD_W = 2 * MAG_W;
	localparam int SHR_W  = PROD_W - FRAC_BITS;

	mag_t               xm_q, ym_q;
	logic               neg_q, run_q, fin_q, done_q;
	logic [1:0]         cnt_q;
	logic [PROD_W-1:0]  acc_q, pp_ext;
	logic [HALF_W-1:0]  xs, ys;
	logic [PP_W-1:0]    pp;
	logic [SHR_W-1:0]   shr;
	mag_t               pm;
	val_t               prod_q;

	// One 32 by 32 partial product per cycle, placed by its half indexes.
	always_comb begin
		xs = cnt_q[0] ? HALF_W'(xm_q[MAG_W-1:HALF_W]) : xm_q[HALF_W-1:0];
		ys = cnt_q[1] ? HALF_W'(ym_q[MAG_W-1:HALF_W]) : ym_q[HALF_W-1:0];
		pp = {{HALF_W{1'b0}}, xs} * {{HALF_W{1'b0}}, ys};
		unique case (cnt_q)
			2'd0:    pp_ext = PROD_W'(pp);
			2'd3:    pp_ext = PROD_W'(pp) << (2 * HALF_W);
			default: pp_ext = PROD_W'(pp) << HALF_W;
		endcase
		shr = acc_q[PROD_W-1:FRAC_BITS];
		pm  = (shr > SHR_W'(SAT_MAG)) ? SAT_MAG : shr[MAG_W-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			xm_q   <= '0;
			ym_q   <= '0;
			neg_q  <= 1'b0;
			run_q  <= 1'b0;
			fin_q  <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
			acc_q  <= '0;
			prod_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				xm_q  <= mag_of(op_a);
				ym_q  <= mag_of(op_b);
				neg_q <= op_a[DIFF_W-1] ^ op_b[DIFF_W-1];
				acc_q <= '0;
				cnt_q <= '0;
				run_q <= 1'b1;
			end else if (run_q) begin
				acc_q <= acc_q + pp_ext;
				cnt_q <= cnt_q + 2'd1;
				if (cnt_q == 2'd3) begin
					run_q <= 1'b0;
					fin_q <= 1'b1;
				end
			end else if (fin_q) begin
				// Truncate the fraction, saturate and restore the sign.
				prod_q <= neg_q ? -val_t'(pm) : val_t'(pm);
				fin_q  <= 1'b0;
				done_q <= 1'b1;
			end
		end
	end

	assign done = done_q;
	assign prod = prod_q;

endmodule

// File: design/rbse_div.sv
module rbse_div import rbse_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic start,
	input  dv_t  num,
	input  dv_t  den,
	output logic done,
	output val_t quo
);

	localparam int NUM_W = MAG_W + FRAC_BITS;
	localparam int STEPS = (NUM_W + 1) / 2;
	localparam int PAD_W = 2 * STEPS;
	localparam int REM_W = MAG_W + 1;
	localparam int CNT_W = $clog2(STEPS);

	logic [PAD_W-1:0] num_q, quo_q, num_n, quo_n;
	mag_t             dm_q, rem_q, rem_n, qm;
	logic [REM_W-1:0] trial;
	logic             neg_q, run_q, fin_q, done_q;
	logic [CNT_W-1:0] cnt_q;
	val_t             res_q;

	// Two restoring division steps per cycle.
	always_comb begin
		rem_n = rem_q;
		num_n = num_q;
		quo_n = quo_q;
		trial = '0;
		for (int i = 0; i < 2; i++) begin
			trial = {rem_n, num_n[PAD_W-1]};
			num_n = num_n << 1;
			if (trial >= {1'b0, dm_q}) begin
				trial = trial - {1'b0, dm_q};
				quo_n = {quo_n[PAD_W-2:0], 1'b1};
			end else begin
				quo_n = {quo_n[PAD_W-2:0], 1'b0};
			end
			rem_n = trial[MAG_W-1:0];
		end
		qm = (quo_q > PAD_W'(SAT_MAG)) ? SAT_MAG : quo_q[MAG_W-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			num_q  <= '0;
			quo_q  <= '0;
			dm_q   <= '0;
			rem_q  <= '0;
			neg_q  <= 1'b0;
			run_q  <= 1'b0;
			fin_q  <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
			res_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				num_q <= PAD_W'({mag_of(num), {FRAC_BITS{1'b0}}});
				dm_q  <= mag_of(den);
				neg_q <= num[DIFF_W-1] ^ den[DIFF_W-1];
				rem_q <= '0;
				quo_q <= '0;
				cnt_q <= '0;
				run_q <= 1'b1;
			end else if (run_q) begin
				num_q <= num_n;
				quo_q <= quo_n;
				rem_q <= rem_n;
				cnt_q <= cnt_q + CNT_W'(1);
				if (cnt_q == CNT_W'(STEPS - 1)) begin
					run_q <= 1'b0;
					fin_q <= 1'b1;
				end
			end else if (fin_q) begin
				// Saturate the quotient and restore the sign.
				res_q  <= neg_q ? -val_t'(qm) : val_t'(qm);
				fin_q  <= 1'b0;
				done_q <= 1'b1;
			end
		end
	end

	assign done = done_q;
	assign quo  = res_q;

endmodule

// File: design/rbse_front.sv
module rbse_front import rbse_pkg::*; (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	output logic                busy,
	input  logic [ACT_W-1:0]    action,
	input  logic [SLOT_W-1:0]   slot,
	input  coord_t              coord_x,
	input  coord_t              coord_y,
	input  coord_t              coord_z,
	input  logic [WEIGHT_W-1:0] weight,
	input  knot_t               knot_value,
	input  logic [PARAM_W-1:0]  param_t,
	input  logic                cfg_valid,
	output logic                cfg_ready,
	input  logic [CIDX_W-1:0]   cfg_index,
	input  logic [CFG_W-1:0]    cfg_data,
	input  logic                pop,
	output qhead_t              head,
	output cfg_t                cfg
);

	cmd_t       q_q [2];
	logic       wp_q, rp_q;
	logic [1:0] cnt_q;
	logic       accept, keep, push;
	cfg_t       cfg_q;

	// Classify the word: loads to a missing slot and unknown actions are dropped.
	always_comb begin
		accept = start && !busy;
		unique case (action)
			ACT_POINT: keep = (slot < SLOT_W'(NUM_PTS));
			ACT_KNOT:  keep = (slot < SLOT_W'(NUM_KNOTS));
			ACT_EVAL:  keep = 1'b1;
			default:   keep = 1'b0;
		endcase
		push = accept && keep;
	end

	// Two-entry queue towards the evaluation engine.
	always_ff @(posedge clk) begin
		if (push) begin
			q_q[wp_q] <= '{kind: action, slot: slot, coord_x: coord_x, coord_y: coord_y,
				coord_z: coord_z, weight: weight, knot_value: knot_value,
				param_t: param_t};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= 1'b0;
			rp_q  <= 1'b0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wp_q <= ~wp_q;
			end
			if (pop) begin
				rp_q <= ~rp_q;
			end
			cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop};
		end
	end

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.seg_order    <= ORDER_W'(3);
			cfg_q.range_start  <= '0;
			cfg_q.range_end    <= PARAM_ONE;
			cfg_q.weight_floor <= CFG_W'(1);
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				REG_ORDER: cfg_q.seg_order    <= cfg_data[ORDER_W-1:0];
				REG_START: cfg_q.range_start  <= cfg_data;
				REG_END:   cfg_q.range_end    <= cfg_data;
				REG_FLOOR: cfg_q.weight_floor <= cfg_data;
			endcase
		end
	end

	assign busy       = (cnt_q == 2'd2);
	assign cfg_ready  = 1'b1;
	assign head.valid = (cnt_q != 2'd0);
	assign head.cmd   = q_q[rp_q];
	assign cfg        = cfg_q;

endmodule

// File: design/rbse_back.sv
module rbse_back import rbse_pkg::*; (
	input  logic   clk,
	input  logic   arst_n,
	input  cfg_t   cfg,
	input  qhead_t head,
	output logic   pop,
	output logic   done,
	output coord_t point_x,
	output coord_t point_y,
	output coord_t point_z,
	output logic   divided
);

	localparam logic [4:0] S_IDLE   = 5'd0;
	localparam logic [4:0] S_MAP    = 5'd1;
	localparam logic [4:0] S_MAPW   = 5'd2;
	localparam logic [4:0] S_COPY   = 5'd3;
	localparam logic [4:0] S_COPYW  = 5'd4;
	localparam logic [4:0] S_RDA    = 5'd5;
	localparam logic [4:0] S_RDB    = 5'd6;
	localparam logic [4:0] S_LIN    = 5'd7;
	localparam logic [4:0] S_LINW   = 5'd8;
	localparam logic [4:0] S_KLO    = 5'd9;
	localparam logic [4:0] S_KHI    = 5'd10;
	localparam logic [4:0] S_ALPHA  = 5'd11;
	localparam logic [4:0] S_ALPHAW = 5'd12;
	localparam logic [4:0] S_STEP   = 5'd13;
	localparam logic [4:0] S_STEPW  = 5'd14;
	localparam logic [4:0] S_WB     = 5'd15;
	localparam logic [4:0] S_FIN    = 5'd16;
	localparam logic [4:0] S_CHK    = 5'd17;
	localparam logic [4:0] S_DIV    = 5'd18;
	localparam logic [4:0] S_DIVW   = 5'd19;
	localparam logic [4:0] S_OUT    = 5'd20;

	logic [4:0]         state_q;
	logic [1:0]         c_q, j_q, r_q, k_q;
	logic               lin_q, div_flag_q, done_q, divided_q;
	logic [PARAM_W-1:0] t_q;
	val_t               u_q, alpha_q;
	knot_t              lo_q, hi_q;
	row_t               ra_q, rb_q, nr_q, cprd_q;
	coord_t             px_q, py_q, pz_q;

	row_t  cp_q [NUM_PTS];
	row_t  d_q  [NUM_PTS];
	knot_t kn_q [NUM_KNOTS];

	logic [1:0]         p, rd_addr, d_waddr;
	logic [SLOT_W-1:0]  k_addr;
	logic               is_lin, full_range, map_mul, cp_we, kn_we, d_we, w_div;
	row_t               d_rd, d_wdata;
	knot_t              kn_rd;
	dv_t                diff_c, den, mul_a, mul_b, div_n, div_d;
	logic               mul_start, mul_done, div_start, div_done;
	val_t               mul_res, div_res, w_v, floor_v;

	// Decode of order, mapping case and perspective division.
	always_comb begin
		p          = cfg.seg_order;
		is_lin     = (cfg.seg_order <= ORDER_W'(1));
		full_range = (cfg.range_start == '0) && (cfg.range_end == PARAM_ONE);
		map_mul    = !full_range && (t_q != '0) && (t_q != PARAM_ONE);
		diff_c     = dv_t'($signed(rb_q[c_q])) - dv_t'($signed(ra_q[c_q]));
		den        = dv_t'(hi_q) - dv_t'(lo_q);
		w_v        = $signed(nr_q[NUM_COMP-1]);
		floor_v    = val_t'({1'b0, cfg.weight_floor});
		w_div      = (w_v != ONE_VAL) && (w_v >= floor_v) && (w_v > val_t'(0));
	end

	// Read addresses of the working rows and the knot store.
	always_comb begin
		unique case (state_q)
			S_RDA:   rd_addr = j_q - 2'd1;
			S_RDB:   rd_addr = j_q;
			default: rd_addr = p;
		endcase
		if (state_q == S_KLO) begin
			k_addr = {1'b0, j_q} - SLOT_W'(1);
		end else begin
			k_addr = {1'b0, j_q} + {1'b0, p} - {1'b0, r_q};
		end
		d_rd  = d_q[rd_addr];
		kn_rd = kn_q[k_addr];
	end

	// Operands of the shared multiplier and divider.
	always_comb begin
		mul_start = 1'b0;
		mul_a     = '0;
		mul_b     = '0;
		div_start = 1'b0;
		div_n     = dv_t'(u_q) - dv_t'(lo_q);
		div_d     = den;
		unique case (state_q)
			S_MAP: begin
				mul_start = map_mul;
				mul_a     = dv_t'({1'b0, t_q});
				mul_b     = dv_t'({1'b0, cfg.range_end}) - dv_t'({1'b0, cfg.range_start});
			end
			S_LIN: begin
				mul_start = 1'b1;
				mul_a     = dv_t'(u_q);
				mul_b     = diff_c;
			end
			S_STEP: begin
				mul_start = 1'b1;
				mul_a     = dv_t'(alpha_q);
				mul_b     = diff_c;
			end
			S_ALPHA: begin
				div_start = (den != '0);
			end
			S_DIV: begin
				div_start = 1'b1;
				div_n     = dv_t'($signed(nr_q[c_q]));
				div_d     = dv_t'(w_v);
			end
			default: begin
			end
		endcase
	end

	// Write ports of the stores.
	always_comb begin
		pop     = (state_q == S_IDLE) && head.valid;
		cp_we   = pop && (head.cmd.kind == ACT_POINT);
		kn_we   = pop && (head.cmd.kind == ACT_KNOT);
		d_we    = (state_q == S_COPYW) || (state_q == S_WB);
		d_waddr = (state_q == S_COPYW) ? k_q : j_q;
		d_wdata = (state_q == S_COPYW) ? cprd_q : nr_q;
	end

	// Control point store and its registered read for the copy sweep.
	always_ff @(posedge clk) begin
		if (cp_we) begin
			cp_q[head.cmd.slot[1:0]] <= {val_t'({{(VAL_W - WEIGHT_W){1'b0}}, head.cmd.weight}),
				val_t'(head.cmd.coord_z), val_t'(head.cmd.coord_y),
				val_t'(head.cmd.coord_x)};
		end
		cprd_q <= cp_q[k_q];
	end

	// Knot store.
	always_ff @(posedge clk) begin
		if (kn_we) begin
			kn_q[head.cmd.slot] <= head.cmd.knot_value;
		end
	end

	// Working rows of the de Boor triangle.
	always_ff @(posedge clk) begin
		if (d_we) begin
			d_q[d_waddr] <= d_wdata;
		end
	end

	// Evaluation sequencer.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			c_q        <= '0;
			j_q        <= '0;
			r_q        <= '0;
			k_q        <= '0;
			lin_q      <= 1'b0;
			div_flag_q <= 1'b0;
			done_q     <= 1'b0;
			divided_q  <= 1'b0;
			t_q        <= '0;
			u_q        <= '0;
			alpha_q    <= '0;
			lo_q       <= '0;
			hi_q       <= '0;
			ra_q       <= '0;
			rb_q       <= '0;
			nr_q       <= '0;
			px_q       <= '0;
			py_q       <= '0;
			pz_q       <= '0;
		end else begin
			done_q <= 1'b0;
			unique case (state_q)
				S_IDLE: begin
					if (pop && (head.cmd.kind == ACT_EVAL)) begin
						t_q     <= head.cmd.param_t;
						state_q <= S_MAP;
					end
				end
				S_MAP: begin
					k_q   <= '0;
					lin_q <= is_lin;
					if (full_range) begin
						u_q     <= val_t'({1'b0, t_q});
						state_q <= S_COPY;
					end else if (t_q == '0) begin
						u_q     <= val_t'({1'b0, cfg.range_start});
						state_q <= S_COPY;
					end else if (t_q == PARAM_ONE) begin
						u_q     <= val_t'({1'b0, cfg.range_end});
						state_q <= S_COPY;
					end else begin
						state_q <= S_MAPW;
					end
				end
				S_MAPW: begin
					if (mul_done) begin
						u_q     <= sat_add(dv_t'({1'b0, cfg.range_start}), dv_t'(mul_res));
						state_q <= S_COPY;
					end
				end
				S_COPY: begin
					state_q <= S_COPYW;
				end
				S_COPYW: begin
					if (k_q == 2'd3) begin
						if (lin_q) begin
							j_q     <= 2'd1;
							state_q <= S_RDA;
						end else begin
							r_q     <= 2'd1;
							j_q     <= p;
							state_q <= S_KLO;
						end
					end else begin
						k_q     <= k_q + 2'd1;
						state_q <= S_COPY;
					end
				end
				S_RDA: begin
					ra_q    <= d_rd;
					state_q <= S_RDB;
				end
				S_RDB: begin
					rb_q    <= d_rd;
					c_q     <= '0;
					state_q <= lin_q ? S_LIN : S_STEP;
				end
				S_LIN: begin
					state_q <= S_LINW;
				end
				S_LINW: begin
					if (mul_done) begin
						nr_q[c_q] <= sat_add(dv_t'($signed(ra_q[c_q])), dv_t'(mul_res));
						if (c_q == 2'd2) begin
							div_flag_q <= 1'b0;
							state_q    <= S_OUT;
						end else begin
							c_q     <= c_q + 2'd1;
							state_q <= S_LIN;
						end
					end
				end
				S_KLO: begin
					lo_q    <= kn_rd;
					state_q <= S_KHI;
				end
				S_KHI: begin
					hi_q    <= kn_rd;
					state_q <= S_ALPHA;
				end
				S_ALPHA: begin
					// Coincident knots give a zero blend factor.
					if (den == '0) begin
						alpha_q <= '0;
						state_q <= S_RDA;
					end else begin
						state_q <= S_ALPHAW;
					end
				end
				S_ALPHAW: begin
					if (div_done) begin
						alpha_q <= div_res;
						state_q <= S_RDA;
					end
				end
				S_STEP: begin
					state_q <= S_STEPW;
				end
				S_STEPW: begin
					if (mul_done) begin
						nr_q[c_q] <= sat_add(dv_t'($signed(ra_q[c_q])), dv_t'(mul_res));
						if (c_q == 2'd3) begin
							state_q <= S_WB;
						end else begin
							c_q     <= c_q + 2'd1;
							state_q <= S_STEP;
						end
					end
				end
				S_WB: begin
					if (j_q == r_q) begin
						if (r_q == p) begin
							state_q <= S_FIN;
						end else begin
							r_q     <= r_q + 2'd1;
							j_q     <= p;
							state_q <= S_KLO;
						end
					end else begin
						j_q     <= j_q - 2'd1;
						state_q <= S_KLO;
					end
				end
				S_FIN: begin
					nr_q    <= d_rd;
					state_q <= S_CHK;
				end
				S_CHK: begin
					c_q <= '0;
					if (w_div) begin
						state_q <= S_DIV;
					end else begin
						div_flag_q <= 1'b0;
						state_q    <= S_OUT;
					end
				end
				S_DIV: begin
					state_q <= S_DIVW;
				end
				S_DIVW: begin
					if (div_done) begin
						nr_q[c_q] <= div_res;
						if (c_q == 2'd2) begin
							div_flag_q <= 1'b1;
							state_q    <= S_OUT;
						end else begin
							c_q     <= c_q + 2'd1;
							state_q <= S_DIV;
						end
					end
				end
				S_OUT: begin
					px_q      <= sat_out($signed(nr_q[0]));
					py_q      <= sat_out($signed(nr_q[1]));
					pz_q      <= sat_out($signed(nr_q[2]));
					divided_q <= div_flag_q;
					done_q    <= 1'b1;
					state_q   <= S_IDLE;
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	rbse_mul u_mul (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (mul_start),
		.op_a   (mul_a),
		.op_b   (mul_b),
		.done   (mul_done),
		.prod   (mul_res)
	);

	rbse_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.num    (div_n),
		.den    (div_d),
		.done   (div_done),
		.quo    (div_res)
	);

	assign done    = done_q;
	assign point_x = px_q;
	assign point_y = py_q;
	assign point_z = pz_q;
	assign divided = divided_q;

endmodule

// File: design/rational_bspline_segment_eval.sv
// Words enter on start while busy is low and pass through a two-entry queue, so a
// new word is taken while the engine still works.
// Every de Boor step uses one 32 by 32 multiplier four times and, unless its knots
// coincide, one divider that retires two quotient bits a cycle; a rational result
// adds three more divisions.
// The result word is on point_x, point_y, point_z and divided for exactly one cycle
// while done is high; the receiver cannot stall it and must take it then.
// Configuration must be written only while no word is in flight; the block itself does not enforce it.
module rational_bspline_segment_eval import rbse_pkg::*; (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	output logic                busy,
	input  logic [ACT_W-1:0]    action,
	input  logic [SLOT_W-1:0]   slot,
	input  coord_t              coord_x,
	input  coord_t              coord_y,
	input  coord_t              coord_z,
	input  logic [WEIGHT_W-1:0] weight,
	input  knot_t               knot_value,
	input  logic [PARAM_W-1:0]  param_t,
	input  logic                cfg_valid,
	output logic                cfg_ready,
	input  logic [CIDX_W-1:0]   cfg_index,
	input  logic [CFG_W-1:0]    cfg_data,
	output logic                done,
	output coord_t              point_x,
	output coord_t              point_y,
	output coord_t              point_z,
	output logic                divided
);

	qhead_t head;
	cfg_t   cfg;
	logic   pop;

	// Front end: handshake, classification, queue and configuration.
	rbse_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (start),
		.busy       (busy),
		.action     (action),
		.slot       (slot),
		.coord_x    (coord_x),
		.coord_y    (coord_y),
		.coord_z    (coord_z),
		.weight     (weight),
		.knot_value (knot_value),
		.param_t    (param_t),
		.cfg_valid  (cfg_valid),
		.cfg_ready  (cfg_ready),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.pop        (pop),
		.head       (head),
		.cfg        (cfg)
	);

	// Back end: stores and the evaluation engine.
	rbse_back u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.cfg     (cfg),
		.head    (head),
		.pop     (pop),
		.done    (done),
		.point_x (point_x),
		.point_y (point_y),
		.point_z (point_z),
		.divided (divided)
	);

endmodule

// File: bench/rbse_checker.sv
module rbse_checker import rbse_pkg::*; (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	input  logic                busy,
	input  logic [ACT_W-1:0]    action,
	input  logic [SLOT_W-1:0]   slot,
	input  coord_t              coord_x,
	input  coord_t              coord_y,
	input  coord_t              coord_z,
	input  logic [WEIGHT_W-1:0] weight,
	input  knot_t               knot_value,
	input  logic [PARAM_W-1:0]  param_t,
	input  logic                cfg_valid,
	input  logic                cfg_ready,
	input  logic [CIDX_W-1:0]   cfg_index,
	input  logic [CFG_W-1:0]    cfg_data,
	input  logic                done,
	input  coord_t              point_x,
	input  coord_t              point_y,
	input  coord_t              point_z,
	input  logic                divided,
	output int                  fail_count,
	output int                  pending,
	output int                  points_checked
);
	timeunit 1ns;
	timeprecision 1ps;

	localparam longint CLIP  = longint'(1) << SAT_EXP;
	localparam longint UNITY = longint'(1) << FRAC_BITS;
	localparam longint CO_HI = (longint'(1) << (COORD_W - 1)) - 1;
	localparam longint CO_LO = -(longint'(1) << (COORD_W - 1));

	typedef struct {
		coord_t x;
		coord_t y;
		coord_t z;
		logic   div;
	} point_t;

	// Shadow copy of the stores and the registers.
	longint        pt_coord [12];
	longint        pt_weight [4];
	longint        knots [6];
	logic [1:0]    seg_order;
	longint        rng_lo;
	longint        rng_hi;
	longint        w_floor;
	point_t        awaited [$];

	function automatic longint clip(longint v);
		if (v > CLIP) begin
			return CLIP;
		end
		if (v < -CLIP) begin
			return -CLIP;
		end
		return v;
	endfunction

	function automatic logic [63:0] magnitude(longint v);
		logic [63:0] m;
		m = v;
		return v < 0 ? -m : m;
	endfunction

	// Fixed-point product, truncated toward zero and saturated.
	function automatic longint fx_mul(longint a, longint b);
		logic [127:0] p;
		longint r;
		p = ({64'b0, magnitude(a)} * {64'b0, magnitude(b)}) >> FRAC_BITS;
		r = (p > 128'(CLIP)) ? CLIP : longint'(p[63:0]);
		return ((a < 0) != (b < 0)) ? -r : r;
	endfunction

	// Fixed-point quotient; the divisor is never zero here.
	function automatic longint fx_div(longint n, longint d);
		logic [127:0] q;
		longint r;
		q = ({64'b0, magnitude(n)} << FRAC_BITS) / {64'b0, magnitude(d)};
		r = (q > 128'(CLIP)) ? CLIP : longint'(q[63:0]);
		return ((n < 0) != (d < 0)) ? -r : r;
	endfunction

	function automatic coord_t to_coord(longint v);
		if (v > CO_HI) begin
			v = CO_HI;
		end else if (v < CO_LO) begin
			v = CO_LO;
		end
		return v[COORD_W-1:0];
	endfunction

	// Maps t onto the sub-range and runs the interpolation or de Boor scheme.
	function automatic point_t eval_point(logic [PARAM_W-1:0] raw_t);
		longint t, u, lo, den, alpha;
		longint d [4][4];
		longint res [4];
		int p;
		point_t pt;
		t = raw_t;
		if (rng_lo == 0 && rng_hi == UNITY) begin
			u = t;
		end else if (t == 0) begin
			u = rng_lo;
		end else if (t == UNITY) begin
			u = rng_hi;
		end else begin
			u = clip(rng_lo + fx_mul(t, rng_hi - rng_lo));
		end
		pt.div = 1'b0;
		if (seg_order <= 1) begin
			for (int c = 0; c < 3; c++) begin
				res[c] = clip(pt_coord[c] + fx_mul(u, pt_coord[3 + c] - pt_coord[c]));
			end
		end else begin
			p = seg_order;
			for (int j = 0; j <= p; j++) begin
				for (int c = 0; c < 3; c++) begin
					d[j][c] = pt_coord[j * 3 + c];
				end
				d[j][3] = pt_weight[j];
			end
			for (int r = 1; r <= p; r++) begin
				for (int j = p; j >= r; j--) begin
					lo = knots[j - 1];
					den = knots[j + p - r] - lo;
					alpha = (den == 0) ? 0 : fx_div(u - lo, den);
					for (int c = 0; c < 4; c++) begin
						d[j][c] = clip(d[j - 1][c] + fx_mul(alpha, d[j][c] - d[j - 1][c]));
					end
				end
			end
			for (int c = 0; c < 4; c++) begin
				res[c] = d[p][c];
			end
			// Perspective division unless the weight is one, too small or not positive.
			if (res[3] != UNITY && res[3] >= w_floor && res[3] > 0) begin
				for (int c = 0; c < 3; c++) begin
					res[c] = fx_div(res[c], res[3]);
				end
				pt.div = 1'b1;
			end
		end
		pt.x = to_coord(res[0]);
		pt.y = to_coord(res[1]);
		pt.z = to_coord(res[2]);
		return pt;
	endfunction

	assign pending = awaited.size();

	// Results are compared before the word taken at the same edge is predicted.
	always @(posedge clk or negedge arst_n) begin
		point_t want;
		if (!arst_n) begin
			foreach (pt_coord[i]) pt_coord[i] = 0;
			foreach (pt_weight[i]) pt_weight[i] = 0;
			foreach (knots[i]) knots[i] = 0;
			seg_order = 2'd3;
			rng_lo = 0;
			rng_hi = UNITY;
			w_floor = 1;
			awaited.delete();
			fail_count = 0;
			points_checked = 0;
		end else begin
			if (done) begin
				points_checked++;
				if (awaited.size() == 0) begin
					fail_count++;
					if (fail_count <= 10) begin
						$display("%0t: result word with nothing awaited: %h %h %h %b",
							$realtime, point_x, point_y, point_z, divided);
					end
				end else begin
					want = awaited.pop_front();
					if (want.x !== point_x || want.y !== point_y || want.z !== point_z ||
							want.div !== divided) begin
						fail_count++;
						if (fail_count <= 10) begin
							$display("%0t: point mismatch: expected %h %h %h %b got %h %h %h %b",
								$realtime, want.x, want.y, want.z, want.div,
								point_x, point_y, point_z, divided);
						end
					end
				end
			end
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					REG_ORDER: seg_order = cfg_data[ORDER_W-1:0];
					REG_START: rng_lo = cfg_data;
					REG_END:   rng_hi = cfg_data;
					REG_FLOOR: w_floor = cfg_data;
				endcase
			end
			if (start && !busy) begin
				if (action == ACT_POINT && slot < 4) begin
					pt_coord[slot * 3]     = coord_x;
					pt_coord[slot * 3 + 1] = coord_y;
					pt_coord[slot * 3 + 2] = coord_z;
					pt_weight[slot]        = weight;
				end else if (action == ACT_KNOT && slot < 6) begin
					knots[slot] = knot_value;
				end else if (action == ACT_EVAL) begin
					awaited = {awaited, eval_point(param_t)};
				end
			end
		end
	end
endmodule

// File: bench/tb_top.sv
module tb_top import rbse_pkg::*;;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int ONE_T = 1 << FRAC_BITS;
	localparam logic [ACT_W-1:0] ACT_UNUSED = 2'd3;

	logic                clk = 1'b0;
	logic                arst_n = 1'b0;
	logic                start = 1'b0;
	logic                busy;
	logic [ACT_W-1:0]    action = ACT_POINT;
	logic [SLOT_W-1:0]   slot = '0;
	coord_t              coord_x = '0;
	coord_t              coord_y = '0;
	coord_t              coord_z = '0;
	logic [WEIGHT_W-1:0] weight = '0;
	knot_t               knot_value = '0;
	logic [PARAM_W-1:0]  param_t = '0;
	logic                cfg_valid = 1'b0;
	logic                cfg_ready;
	logic [CIDX_W-1:0]   cfg_index = REG_ORDER;
	logic [CFG_W-1:0]    cfg_data = '0;
	logic                done;
	coord_t              point_x;
	coord_t              point_y;
	coord_t              point_z;
	logic                divided;
	int                  fail_count;
	int                  pending;
	int                  points_checked;
	int                  idle_pct;
	int                  words_sent;
	int                  evals_sent;

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	rational_bspline_segment_eval uut (.*);

	rbse_checker u_checker (.*);

	initial begin
		#10_000_000;
		$display("FAIL rational_bspline_segment_eval");
		$finish;
	end

	function automatic coord_t rand_coord();
		case ($urandom_range(7))
			0, 1:    return coord_t'({$urandom, $urandom});
			2:       return $urandom_range(1) ? coord_t'({1'b0, {47{1'b1}}}) : coord_t'({1'b1, 47'b0});
			default: return coord_t'($signed($urandom)) <<< $urandom_range(4);
		endcase
	endfunction

	function automatic logic [WEIGHT_W-1:0] rand_weight();
		case ($urandom_range(9))
			0:       return $urandom;
			1:       return '0;
			2, 3:    return ONE_T;
			default: return ONE_T / 2 + $urandom_range(ONE_T);
		endcase
	endfunction

	function automatic logic [PARAM_W-1:0] rand_t();
		case ($urandom_range(9))
			0:       return '0;
			1:       return PARAM_W'(ONE_T);
			2:       return PARAM_W'($urandom_range(2 * ONE_T - 1, ONE_T));
			default: return PARAM_W'($urandom_range(ONE_T));
		endcase
	endfunction

	// Presents one word and holds it until it is taken; start stays high after unless an idle pause is drawn.
	task automatic send_word(logic [ACT_W-1:0] act, logic [SLOT_W-1:0] s, coord_t x, coord_t y,
			coord_t z, logic [WEIGHT_W-1:0] w, knot_t k, logic [PARAM_W-1:0] t);
		start      <= 1'b1;
		action     <= act;
		slot       <= s;
		coord_x    <= x;
		coord_y    <= y;
		coord_z    <= z;
		weight     <= w;
		knot_value <= k;
		param_t    <= t;
		do @(posedge clk); while (busy);
		words_sent++;
		if (act == ACT_EVAL) begin
			evals_sent++;
		end
		if ($urandom_range(99) < idle_pct) begin
			start <= 1'b0;
			repeat ($urandom_range(6, 1)) @(posedge clk);
		end
	endtask

	task automatic load_point(int s, logic [WEIGHT_W-1:0] w);
		send_word(ACT_POINT, SLOT_W'(s), rand_coord(), rand_coord(), rand_coord(), w, $urandom,
			rand_t());
	endtask

	task automatic load_knot(int s, knot_t k);
		send_word(ACT_KNOT, SLOT_W'(s), rand_coord(), rand_coord(), rand_coord(), $urandom, k,
			rand_t());
	endtask

	task automatic evaluate(logic [PARAM_W-1:0] t);
		send_word(ACT_EVAL, SLOT_W'($urandom), rand_coord(), rand_coord(), rand_coord(), $urandom,
			$urandom, t);
	endtask

	task automatic write_reg(logic [CIDX_W-1:0] idx, logic [CFG_W-1:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		@(posedge clk);
	endtask

	// Waits for every result and lets a trailing load word drain.
	task automatic drain();
		start <= 1'b0;
		@(posedge clk);
		wait (pending == 0);
		repeat (20) @(posedge clk);
	endtask

	// A well-formed segment: all points, ordered knots, then a few evaluations.
	task automatic send_segment();
		knot_t k;
		int    s0;
		s0 = $urandom_range(3);
		for (int i = 0; i < 4; i++) begin
			load_point((s0 + i) % 4, rand_weight());
		end
		k = $signed($urandom_range(4 * ONE_T)) - 2 * ONE_T;
		for (int i = 0; i < 6; i++) begin
			load_knot(i, k);
			if ($urandom_range(4) != 0) begin
				k = k + $urandom_range(2 * ONE_T);
			end
		end
		repeat ($urandom_range(4, 1)) evaluate(rand_t());
	endtask

	task automatic send_noise();
		case ($urandom_range(5))
			0: load_point($urandom_range(7), rand_weight());
			1: load_knot($urandom_range(7), $urandom);
			2: send_word(ACT_UNUSED, SLOT_W'($urandom), rand_coord(), rand_coord(), rand_coord(),
				$urandom, $urandom, rand_t());
			default: evaluate(rand_t());
		endcase
	endtask

	initial begin
		logic [1:0]       orders [8] = '{2'd3, 2'd1, 2'd2, 2'd0, 2'd3, 2'd2, 2'd1, 2'd3};
		int               idles [4] = '{0, 66, 0, 6};
		logic [CFG_W-1:0] lo_v, hi_v, fl_v;
		int               base;
		words_sent = 0;
		evals_sent = 0;
		idle_pct = 0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed part: extremes, every action, ignored words, range endpoints.
		write_reg(REG_ORDER, CFG_W'(3));
		send_word(ACT_POINT, 0, {1'b0, {47{1'b1}}}, {1'b1, 47'b0}, '1, '1, '0, '0);
		send_word(ACT_POINT, 1, {1'b1, 47'b0}, {1'b0, {47{1'b1}}}, '0, '0, '0, '1);
		load_point(2, ONE_T);
		load_point(3, ONE_T);
		load_knot(0, {1'b1, 31'b0});
		load_knot(1, {1'b0, {31{1'b1}}});
		for (int i = 0; i < 6; i++) begin
			load_knot(i, (i - 2) * ONE_T);
		end
		evaluate(0);
		evaluate(PARAM_W'(ONE_T));
		evaluate('1);
		load_point(7, ONE_T);
		load_knot(6, ONE_T);
		send_word(ACT_UNUSED, 7, '1, '1, '1, '1, '1, '1);
		load_point(0, ONE_T);
		load_point(1, 3 * ONE_T);
		evaluate(PARAM_W'(ONE_T / 2));
		drain();

		// Random phases, each writing a register setting and choosing an idling mix.
		for (int ph = 0; ph < 8; ph++) begin
			case (ph % 4)
				0: begin lo_v = 0; hi_v = CFG_W'(ONE_T); end
				1: begin lo_v = CFG_W'(ONE_T); hi_v = 0; end
				2: begin
					lo_v = CFG_W'($urandom_range(ONE_T));
					hi_v = CFG_W'($urandom_range(ONE_T));
				end
				default: begin lo_v = CFG_W'(ONE_T / 4); hi_v = CFG_W'(ONE_T); end
			endcase
			fl_v = CFG_W'((ph == 1) ? 0 : (ph == 2) ? ONE_T :
				(ph == 5) ? $urandom_range(ONE_T) : 1);
			write_reg(REG_ORDER, CFG_W'(orders[ph]));
			write_reg(REG_START, lo_v);
			write_reg(REG_END, hi_v);
			write_reg(REG_FLOOR, fl_v);
			idle_pct = idles[ph % 4];
			base = words_sent;
			while (words_sent - base < 128) begin
				if ($urandom_range(9) < 7) begin
					send_segment();
				end else begin
					send_noise();
				end
			end
			drain();
		end

		repeat (50) @(posedge clk);
		$display("Sent %0d words (%0d evaluations) over eight register settings;", words_sent,
			evals_sent);
		$display("%0d result words checked, %0d mismatches.", points_checked, fail_count);
		if (fail_count == 0) begin
			$display("PASS rational_bspline_segment_eval");
		end else begin
			$display("FAIL rational_bspline_segment_eval");
		end
		$finish;
	end
endmodule
